// File: sv/assert_macros.svh
// Assertion helpers, clocked on the rising edge and disabled while in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(label, clk, rstn, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (cond) |-> (expr)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rstn, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (cond) |=> (expr)) \
        else $error("assertion failed: next-cycle implication");

`endif

// File: sv/iovs_pkg.sv
`default_nettype none

package iovs_pkg;

    localparam int ID_W               = 8;
    localparam int DEFAULT_OPEN_SLOTS = 8;

    localparam int QUEUE_DEPTH = 4;
    localparam int Q_PTR_W     = $clog2(QUEUE_DEPTH);
    localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

    localparam logic KIND_START = 1'b0;
    localparam logic KIND_END   = 1'b1;

    localparam logic STATUS_PAIR = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    typedef struct packed {
        logic            is_end;
        logic [ID_W-1:0] id;
    } cmd_t;

endpackage

`default_nettype wire

// File: sv/iovs_ram.sv
`default_nettype none

module iovs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: sv/iovs_front.sv
`default_nettype none

module iovs_front
    import iovs_pkg::*;
(
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_tvalid,
    output logic                 s_tready,
    input  wire logic [ID_W-1:0] s_tdata,   // [7:0] segment_id
    input  wire logic [0:0]      s_tuser,   // [0] event_kind
    output logic                 cmd_vld,
    input  wire logic            cmd_rdy,
    output cmd_t                 cmd
);

    logic hold_vld_reg;
    logic hold_vld_next;
    cmd_t cmd_reg;
    cmd_t cmd_next;
    logic take;

    assign s_tready = !hold_vld_reg || cmd_rdy;
    assign take     = s_tvalid && s_tready;

    always_comb begin
        hold_vld_next = hold_vld_reg;
        cmd_next      = cmd_reg;
        if (cmd_vld && cmd_rdy) begin
            hold_vld_next = 1'b0;
        end
        if (take) begin
            hold_vld_next   = 1'b1;
            cmd_next.is_end = (s_tuser[0] == KIND_END);
            cmd_next.id     = s_tdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_vld_reg <= 1'b0;
        end else begin
            hold_vld_reg <= hold_vld_next;
        end
        cmd_reg <= cmd_next;
    end

    assign cmd_vld = hold_vld_reg;
    assign cmd     = cmd_reg;

endmodule

`default_nettype wire

// File: sv/iovs_queue.sv
`default_nettype none

module iovs_queue
    import iovs_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic in_vld,
    output logic      in_rdy,
    input  cmd_t      in_cmd,
    output logic      out_vld,
    input  wire logic out_rdy,
    output cmd_t      out_cmd
);

    cmd_t               entry_reg [QUEUE_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0] count_reg, count_next;
    logic               push, pop;

    assign in_rdy  = (count_reg != Q_CNT_W'(QUEUE_DEPTH));
    assign out_vld = (count_reg != '0);
    assign push    = in_vld && in_rdy;
    assign pop     = out_vld && out_rdy;
    assign out_cmd = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == Q_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == Q_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (push) begin
            entry_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

`default_nettype wire

// File: sv/iovs_engine.sv
`default_nettype none

module iovs_engine
    import iovs_pkg::*;
#(
    parameter int OPEN_SLOTS = DEFAULT_OPEN_SLOTS
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              q_vld,
    output logic                   q_pop,
    input  cmd_t                   q_cmd,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [2*ID_W-1:0]      m_tdata,   // [7:0] open_id, [15:8] new_id
    output logic [0:0]             m_tuser,   // [0] status
    output logic                   m_tlast    // last_of_run
);

    localparam int SLOT_W = $clog2(OPEN_SLOTS);

    logic [OPEN_SLOTS-1:0] valid_reg, valid_next;
    logic [OPEN_SLOTS-1:0] pending_reg, pending_next;
    logic [OPEN_SLOTS-1:0] pend_left;
    logic [ID_W-1:0]       cur_id_reg, cur_id_next;
    logic                  cur_end_reg, cur_end_next;
    logic                  d_vld_reg, d_vld_next;
    logic                  d_ovf_reg, d_ovf_next;
    logic                  d_last_reg, d_last_next;
    logic [SLOT_W-1:0]     d_idx_reg, d_idx_next;
    logic                  m_vld_reg, m_vld_next;
    logic [ID_W-1:0]       m_open_reg, m_open_next;
    logic [ID_W-1:0]       m_new_reg, m_new_next;
    logic                  m_status_reg, m_status_next;
    logic                  m_last_reg, m_last_next;

    logic [SLOT_W-1:0] free_idx, rd_idx;
    logic [ID_W-1:0]   ram_rdata;
    logic              busy, dispatch, full, out_free, drain, issue, ram_we;

    always_comb begin
        free_idx = '0;
        for (int i = OPEN_SLOTS - 1; i >= 0; i--) begin
            if (!valid_reg[i]) begin
                free_idx = SLOT_W'(i);
            end
        end
    end

    always_comb begin
        rd_idx = '0;
        for (int i = OPEN_SLOTS - 1; i >= 0; i--) begin
            if (pending_reg[i]) begin
                rd_idx = SLOT_W'(i);
            end
        end
    end

    assign busy      = (|pending_reg) || d_vld_reg;
    assign dispatch  = q_vld && !busy;
    assign q_pop     = !busy;
    assign full      = &valid_reg;
    assign out_free  = !m_vld_reg || m_tready;
    assign drain     = d_vld_reg && (cur_end_reg || out_free);
    assign issue     = (|pending_reg) && (!d_vld_reg || drain);
    assign ram_we    = dispatch && !q_cmd.is_end && !full;
    assign pend_left = pending_reg & ~(OPEN_SLOTS'(1) << rd_idx);

    iovs_ram #(
        .WIDTH (ID_W),
        .DEPTH (OPEN_SLOTS)
    ) u_slot_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (free_idx),
        .wdata (q_cmd.id),
        .re    (issue),
        .raddr (rd_idx),
        .rdata (ram_rdata)
    );

    always_comb begin
        valid_next    = valid_reg;
        pending_next  = pending_reg;
        cur_id_next   = cur_id_reg;
        cur_end_next  = cur_end_reg;
        d_vld_next    = d_vld_reg;
        d_ovf_next    = d_ovf_reg;
        d_last_next   = d_last_reg;
        d_idx_next    = d_idx_reg;
        m_vld_next    = m_vld_reg;
        m_open_next   = m_open_reg;
        m_new_next    = m_new_reg;
        m_status_next = m_status_reg;
        m_last_next   = m_last_reg;

        if (m_tready) begin
            m_vld_next = 1'b0;
        end

        if (drain) begin
            d_vld_next = 1'b0;
            if (cur_end_reg) begin
                if (ram_rdata == cur_id_reg) begin
                    valid_next[d_idx_reg] = 1'b0;
                end
            end else begin
                m_vld_next    = 1'b1;
                m_open_next   = d_ovf_reg ? '0 : ram_rdata;
                m_new_next    = cur_id_reg;
                m_status_next = d_ovf_reg ? STATUS_FULL : STATUS_PAIR;
                m_last_next   = d_last_reg;
            end
        end

        if (issue) begin
            pending_next = pend_left;
            d_vld_next   = 1'b1;
            d_ovf_next   = 1'b0;
            d_last_next  = ~|pend_left;
            d_idx_next   = rd_idx;
        end

        if (dispatch) begin
            cur_id_next  = q_cmd.id;
            cur_end_next = q_cmd.is_end;
            if (q_cmd.is_end) begin
                pending_next = valid_reg;
            end else if (full) begin
                d_vld_next  = 1'b1;
                d_ovf_next  = 1'b1;
                d_last_next = 1'b1;
            end else begin
                pending_next         = valid_reg;
                valid_next[free_idx] = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg   <= '0;
            pending_reg <= '0;
            d_vld_reg   <= 1'b0;
            m_vld_reg   <= 1'b0;
        end else begin
            valid_reg   <= valid_next;
            pending_reg <= pending_next;
            d_vld_reg   <= d_vld_next;
            m_vld_reg   <= m_vld_next;
        end
        cur_id_reg   <= cur_id_next;
        cur_end_reg  <= cur_end_next;
        d_ovf_reg    <= d_ovf_next;
        d_last_reg   <= d_last_next;
        d_idx_reg    <= d_idx_next;
        m_open_reg   <= m_open_next;
        m_new_reg    <= m_new_next;
        m_status_reg <= m_status_next;
        m_last_reg   <= m_last_next;
    end

    assign m_tvalid = m_vld_reg;
    assign m_tdata  = {m_new_reg, m_open_reg};
    assign m_tuser  = m_status_reg;
    assign m_tlast  = m_last_reg;

endmodule

`default_nettype wire

// File: sv/interval_overlap_sweep.sv
// Sweep-line overlap finder over endpoint events sorted by coordinate.
// Input beat: s_tuser[0] = event kind (0 start, 1 end), s_tdata = segment id.
// Output beat: m_tdata[7:0] = open id, m_tdata[15:8] = new id,
//   m_tuser[0] = status (0 overlap pair, 1 open set full), m_tlast = last
//   result of the event.
// A start beat yields one pair per open slot in ascending slot order, then
// takes the lowest free slot; with all slots open it yields one full beat
// and is dropped. An end beat frees every slot holding its id, no output.
// Input beats pass a register slice and a 4-entry command queue, so the
// input side keeps taking beats while the engine works, until the queue fills.
// The engine walks the open slots through a slot RAM with registered read,
// one slot per cycle while the output is not stalled. Within an event, the
// output is one beat per cycle while m_tready stays high.
// A low m_tready holds the output register and pauses a start beat's slot walk.
// Reset (aresetn low, synchronous) empties the queue and closes all slots.
`default_nettype none
`include "assert_macros.svh"

module interval_overlap_sweep
    import iovs_pkg::*;
#(
    parameter int OPEN_SLOTS = DEFAULT_OPEN_SLOTS
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [ID_W-1:0]   s_tdata,   // [7:0] segment_id
    input  wire logic [0:0]        s_tuser,   // [0] event_kind
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [2*ID_W-1:0]      m_tdata,   // [7:0] open_id, [15:8] new_id
    output logic [0:0]             m_tuser,   // [0] status
    output logic                   m_tlast
);

    cmd_t front_cmd, q_cmd;
    logic front_vld, front_rdy;
    logic q_vld, q_pop;
    logic full_beat;

    iovs_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .cmd_vld  (front_vld),
        .cmd_rdy  (front_rdy),
        .cmd      (front_cmd)
    );

    iovs_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_vld  (front_vld),
        .in_rdy  (front_rdy),
        .in_cmd  (front_cmd),
        .out_vld (q_vld),
        .out_rdy (q_pop),
        .out_cmd (q_cmd)
    );

    iovs_engine #(
        .OPEN_SLOTS (OPEN_SLOTS)
    ) u_engine (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_vld    (q_vld),
        .q_pop    (q_pop),
        .q_cmd    (q_cmd),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    assign full_beat = m_tvalid && (m_tuser[0] == STATUS_FULL);

    `ASSERT_IMPL(a_full_is_last, aclk, aresetn, full_beat, m_tlast)
    `ASSERT_IMPL(a_full_no_open, aclk, aresetn, full_beat, m_tdata[ID_W-1:0] == '0)
    `ASSERT_NEXT(a_front_loads, aclk, aresetn, s_tvalid && s_tready, front_vld)

endmodule

`default_nettype wire

// File: tb/sv/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import iovs_pkg::*;

    localparam int SLOTS = DEFAULT_OPEN_SLOTS;

    typedef struct packed {
        logic [ID_W-1:0] open_id;
        logic [ID_W-1:0] new_id;
        logic            status;
        logic            last;
    } pair_beat_t;

    // Tracks the open set and holds the overlap beats still owed by the block.
    class overlap_tracker;
        logic [ID_W-1:0] slot_id [SLOTS];
        bit              slot_open [SLOTS];
        pair_beat_t      pending_pairs [$];
        int              errors;

        function new();
            foreach (slot_id[i]) begin
                slot_id[i]   = '0;
                slot_open[i] = 1'b0;
            end
            errors = 0;
        endfunction

        function int n_open();
            int n;
            n = 0;
            foreach (slot_open[i])
                if (slot_open[i])
                    n++;
            return n;
        endfunction

        // Caller makes sure at least one slot is open.
        function logic [ID_W-1:0] pick_open();
            int              k;
            logic [ID_W-1:0] id;
            k  = $urandom_range(n_open() - 1);
            id = '0;
            foreach (slot_open[i])
                if (slot_open[i]) begin
                    if (k == 0)
                        id = slot_id[i];
                    k--;
                end
            return id;
        endfunction

        function void note_event(logic kind, logic [ID_W-1:0] id);
            int         free_idx;
            int         n_before;
            pair_beat_t b;
            if (kind == KIND_END) begin
                foreach (slot_open[i])
                    if (slot_open[i] && slot_id[i] == id) begin
                        slot_open[i] = 1'b0;
                        slot_id[i]   = '0;
                    end
                return;
            end
            free_idx = -1;
            for (int i = SLOTS - 1; i >= 0; i--)
                if (!slot_open[i])
                    free_idx = i;
            if (free_idx < 0) begin
                b = '{open_id: '0, new_id: id, status: STATUS_FULL, last: 1'b1};
                pending_pairs.push_back(b);
                return;
            end
            n_before = pending_pairs.size();
            foreach (slot_open[i])
                if (slot_open[i]) begin
                    b = '{open_id: slot_id[i], new_id: id, status: STATUS_PAIR, last: 1'b0};
                    pending_pairs.push_back(b);
                end
            if (pending_pairs.size() > n_before) begin
                b      = pending_pairs.pop_back();
                b.last = 1'b1;
                pending_pairs.push_back(b);
            end
            slot_id[free_idx]   = id;
            slot_open[free_idx] = 1'b1;
        endfunction

        function void flag(string what, pair_beat_t want, pair_beat_t got);
            errors++;
            if (errors <= 10)
                $display("%0t %s: expected %h %h %b %b, got %h %h %b %b",
                         $time, what, want.open_id, want.new_id, want.status, want.last,
                         got.open_id, got.new_id, got.status, got.last);
        endfunction

        function void check_result(pair_beat_t got);
            pair_beat_t want;
            if (pending_pairs.size() == 0) begin
                flag("unexpected beat", '0, got);
                return;
            end
            want = pending_pairs.pop_front();
            if (got.open_id !== want.open_id || got.new_id !== want.new_id ||
                got.status !== want.status || got.last !== want.last)
                flag("mismatch", want, got);
        endfunction
    endclass

    logic              aclk;
    logic              aresetn;
    logic              s_tvalid;
    logic              s_tready;
    logic [ID_W-1:0]   s_tdata;
    logic [0:0]        s_tuser;
    logic              m_tvalid;
    logic              m_tready;
    logic [2*ID_W-1:0] m_tdata;
    logic [0:0]        m_tuser;
    logic              m_tlast;

    overlap_tracker tracker = new();
    int             n_taken = 0;
    int             burst_left = 0;

    interval_overlap_sweep i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                tracker.note_event(s_tuser[0], s_tdata);
                n_taken++;
            end
            if (m_tvalid && m_tready)
                tracker.check_result('{open_id: m_tdata[ID_W-1:0],
                                       new_id:  m_tdata[2*ID_W-1:ID_W],
                                       status:  m_tuser[0],
                                       last:    m_tlast});
        end
    end

    // Receiver: changing stall patterns plus one long hold-off to back up the input.
    initial begin : rx_side
        int mode;
        int left;
        bit held;
        m_tready = 1'b0;
        held     = 1'b0;
        mode     = 0;
        left     = 0;
        forever begin
            @(negedge aclk);
            if (!held && n_taken >= 40) begin
                held     = 1'b1;
                m_tready = 1'b0;
                repeat (400) @(negedge aclk);
            end
            if (left == 0) begin
                mode = $urandom_range(3);
                left = $urandom_range(10, 80);
            end
            left--;
            case (mode)
                0: m_tready = 1'b1;
                1: m_tready = ($urandom_range(1) == 1);
                2: m_tready = ($urandom_range(4) == 0);
                default: m_tready = ~m_tready;
            endcase
        end
    end

    // Called at a falling edge; returns at a falling edge after the beat is taken.
    task automatic send_event(input logic kind, input logic [ID_W-1:0] id);
        s_tvalid   = 1'b1;
        s_tuser[0] = kind;
        s_tdata    = id;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        if (burst_left > 1) begin
            burst_left--;
        end else begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge aclk);
            burst_left = ($urandom_range(3) == 0) ? 40 : $urandom_range(1, 12);
        end
    endtask

    task automatic random_events(input int n_items);
        int              counted;
        int              target;
        int              r;
        logic [ID_W-1:0] id;
        counted = 0;
        target  = 0;
        while (counted < n_items) begin
            if (counted % 25 == 0)
                target = $urandom_range(0, SLOTS + 1);
            r = $urandom_range(99);
            if (r < 8) begin
                // noise: end of an id that is most likely not open
                send_event(KIND_END, 8'($urandom_range(1, 255)));
            end else if (tracker.n_open() > 0 && (tracker.n_open() > target || r < 30)) begin
                send_event(KIND_END, tracker.pick_open());
                counted++;
            end else begin
                if (tracker.n_open() > 0 && r > 90)
                    id = tracker.pick_open();
                else
                    id = 8'($urandom_range(1, 255));
                send_event(KIND_START, id);
                counted++;
            end
        end
    endtask

    initial begin : main_seq
        logic [ID_W-1:0] fill_ids [7];
        fill_ids   = '{8'h80, 8'h7F, 8'h55, 8'hAA, 8'h01, 8'hFE, 8'h33};
        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser[0] = KIND_START;
        repeat (9) @(negedge aclk);
        aresetn = 1'b1;

        send_event(KIND_START, 8'h01);   // nothing open yet
        send_event(KIND_START, 8'hFF);
        send_event(KIND_START, 8'h01);   // same id twice
        send_event(KIND_END,   8'h01);   // frees both copies
        send_event(KIND_END,   8'h4D);   // id not open
        foreach (fill_ids[i])
            send_event(KIND_START, fill_ids[i]);
        send_event(KIND_START, 8'h99);   // open set full
        send_event(KIND_END,   8'hFF);
        send_event(KIND_START, 8'h42);   // reuses the freed slot
        while (tracker.n_open() > 0)
            send_event(KIND_END, tracker.pick_open());

        random_events(200);

        s_tvalid = 1'b0;
        while (tracker.pending_pairs.size() != 0)
            @(posedge aclk);
        repeat (50) @(posedge aclk);

        if (tracker.errors == 0 && tracker.pending_pairs.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// File: sim.f
+incdir+sv
sv/iovs_pkg.sv
sv/iovs_ram.sv
sv/iovs_front.sv
sv/iovs_queue.sv
sv/iovs_engine.sv
sv/interval_overlap_sweep.sv
tb/sv/tb.sv
